@@ rtl/qcw_pkg.sv @@
// shared types and constants of the quadtree coverage walker
package qcw_pkg;

    localparam int LEVEL_W   = 4;
    localparam int COORD_W   = 15;
    localparam int CODE_W    = 2;
    localparam int POS_W     = 2;
    // one stack word: saved position over saved base column over saved base row
    localparam int STACK_W   = POS_W + 2 * COORD_W;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 4'd12;

    // coverage codes
    typedef enum logic [CODE_W-1:0] {
        CODE_NONE    = 2'd0,
        CODE_PARTIAL = 2'd1,
        CODE_FULL    = 2'd2,
        CODE_SPARE   = 2'd3
    } code_t;

    localparam logic [POS_W-1:0] POS_LAST = 2'd3;

endpackage

@@ rtl/quadtree_coverage_walker.sv @@
// top level: depth-first quadtree coverage walker with a level stack in block memory
// result: registered; while an item closes levels, each parent entry that it reads back
//   passes the stack read register and ST_POP first (closing level 1 reads none)
// throughput: one item per cycle while no level closes and the result is not stalled
// reset: aresetn (synchronous, active low) returns the walk to level 1, position 0, base 0
//   and max_level to 12; the stack memory is not cleared, entries are written before read
module quadtree_coverage_walker
    import qcw_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write: max_level
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LEVEL_W-1:0]    cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [1:0] code, rest zero
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [14:0] tile_column, [29:15] tile_row,
                                             // [33:30] tile_zoom, [34] next_is_leaf_bit
    output logic [M_TUSER_W-1:0]  m_tuser,   // [0] tile_valid, [1] code_error
    output logic                  m_tlast    // walk_done
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [5:0] DEPTH_CMP = 6'(STACK_DEPTH);
    localparam logic [LEVEL_W-1:0] LEVEL_LIM =
        (STACK_DEPTH < 15) ? LEVEL_W'(STACK_DEPTH) : 4'd15;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_POP
    } state_t;

    function automatic logic in_stack(input logic [LEVEL_W-1:0] lvl);
        return {2'b00, lvl} < DEPTH_CMP;
    endfunction

    // control and walk state
    state_t              state_reg, state_next;
    logic [LEVEL_W-1:0]  max_level_reg;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COORD_W-1:0]  base_col_reg, base_col_next;
    logic [COORD_W-1:0]  base_row_reg, base_row_next;
    logic                rd_oob_reg, rd_oob_next;

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic                tile_valid_reg, tile_valid_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [LEVEL_W-1:0]  zoom_reg, zoom_next;
    logic                done_reg, done_next;
    logic                leaf_out_reg, leaf_out_next;
    logic                err_reg, err_next;

    // stack memory
    logic [STACK_W-1:0]  stack_mem [STACK_DEPTH];
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [STACK_W-1:0]  wr_data;
    logic [STACK_W-1:0]  rd_data_reg;

    logic [LEVEL_W-1:0]  emax;
    logic                s_xfer;
    code_t               code_in;
    logic                leaf;
    logic [COORD_W-1:0]  child_col, child_row;
    logic                want_pop;
    logic                finish;
    logic [LEVEL_W-1:0]  lvl_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_xfer    = s_tvalid && s_tready;
    assign code_in   = code_t'(s_tdata[CODE_W-1:0]);

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'd0, leaf_out_reg, zoom_reg, row_reg, col_reg};
    assign m_tuser   = {err_reg, tile_valid_reg};
    assign m_tlast   = done_reg;

    // effective maximum level, limited to 1 .. min(15, stack depth)
    always_comb begin
        emax = max_level_reg;
        if (emax == '0) begin
            emax = 4'd1;
        end
        if (emax > LEVEL_LIM) begin
            emax = LEVEL_LIM;
        end
    end

    assign leaf      = level_reg >= emax;
    assign child_col = base_col_reg + COORD_W'(pos_reg[0]);
    assign child_row = base_row_reg + COORD_W'(pos_reg[1]);

    // walk sequencer
    always_comb begin
        state_next      = state_reg;
        level_next      = level_reg;
        pos_next        = pos_reg;
        base_col_next   = base_col_reg;
        base_row_next   = base_row_reg;
        rd_oob_next     = rd_oob_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        tile_valid_next = tile_valid_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        zoom_next       = zoom_reg;
        done_next       = done_reg;
        leaf_out_next   = leaf_out_reg;
        err_next        = err_reg;
        wr_en           = 1'b0;
        wr_addr         = AW'(level_reg);
        wr_data         = {pos_reg, base_col_reg, base_row_reg};
        rd_en           = 1'b0;
        lvl_dec         = level_reg - 4'd1;
        rd_addr         = AW'(lvl_dec);
        want_pop        = 1'b0;
        finish          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    tile_valid_next = (code_in == CODE_FULL);
                    col_next        = (code_in == CODE_FULL) ? child_col : '0;
                    row_next        = (code_in == CODE_FULL) ? child_row : '0;
                    zoom_next       = (code_in == CODE_FULL) ? level_reg : '0;
                    err_next        = (code_in == CODE_PARTIAL) && leaf;
                    done_next       = 1'b0;
                    if (code_in == CODE_PARTIAL && !leaf) begin
                        // open the child level, saving this one
                        wr_en         = in_stack(level_reg);
                        level_next    = level_reg + 4'd1;
                        base_col_next = {child_col[COORD_W-2:0], 1'b0};
                        base_row_next = {child_row[COORD_W-2:0], 1'b0};
                        pos_next      = '0;
                        finish        = 1'b1;
                    end else if (pos_reg != POS_LAST) begin
                        pos_next = pos_reg + 2'd1;
                        finish   = 1'b1;
                    end else begin
                        want_pop = 1'b1;
                    end
                end
            end
            ST_POP: begin
                // parent entry read in the previous cycle
                if (rd_oob_reg) begin
                    base_col_next = '0;
                    base_row_next = '0;
                    pos_next      = 2'd1;
                    finish        = 1'b1;
                end else begin
                    base_col_next = rd_data_reg[2*COORD_W-1:COORD_W];
                    base_row_next = rd_data_reg[COORD_W-1:0];
                    if (rd_data_reg[STACK_W-1 -: POS_W] != POS_LAST) begin
                        pos_next = rd_data_reg[STACK_W-1 -: POS_W] + 2'd1;
                        finish   = 1'b1;
                    end else begin
                        want_pop = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // close the current level: end of walk or read of the parent entry
        if (want_pop) begin
            if (lvl_dec == '0) begin
                done_next     = 1'b1;
                level_next    = 4'd1;
                pos_next      = '0;
                base_col_next = '0;
                base_row_next = '0;
                finish        = 1'b1;
            end else begin
                level_next  = lvl_dec;
                rd_en       = in_stack(lvl_dec);
                rd_oob_next = !in_stack(lvl_dec);
                state_next  = ST_POP;
            end
        end

        if (finish) begin
            state_next    = ST_IDLE;
            m_tvalid_next = 1'b1;
            leaf_out_next = level_next >= emax;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_level_reg <= MAX_LEVEL_RST;
            level_reg     <= 4'd1;
            pos_reg       <= '0;
            base_col_reg  <= '0;
            base_row_reg  <= '0;
            rd_oob_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            pos_reg      <= pos_next;
            base_col_reg <= base_col_next;
            base_row_reg <= base_row_next;
            rd_oob_reg   <= rd_oob_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                max_level_reg <= cfg_data;
            end
        end
        tile_valid_reg <= tile_valid_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        zoom_reg       <= zoom_next;
        done_reg       <= done_next;
        leaf_out_reg   <= leaf_out_next;
        err_reg        <= err_next;
    end

    // stack memory: a pop never reads an entry written in the same cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

endmodule

@@ rtl/qcw_checker.sv @@
// port checker for the quadtree coverage walker, bound to the top level
module qcw_checker
    import qcw_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser,
    input logic                  m_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled result changed");

    // no input transfer while a result waits and is not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tready))
    else $error("input taken over a blocked result");

    // results without a tile carry zero coordinates and zoom
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[33:0] == 34'd0)
    else $error("tile fields set without a tile");

    // a full tile has a non-zero zoom
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[33:30] != 4'd0)
    else $error("full tile at zoom zero");

    // a code error never reports a tile
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("code error with a tile");

endmodule

bind quadtree_coverage_walker qcw_checker u_qcw_checker (.*);
